// ===== rtl/dncd_pkg.sv =====
`default_nettype none

package dncd_pkg;

	localparam logic [23:0] GREG_OFFSET = 24'd68569;
	localparam logic [23:0] JUL_OFFSET  = 24'd1401;

	// reciprocal multipliers: floor(x / C) == (x * MUL) >> SHIFT over the operand range
	localparam int          N_SHIFT  = 44;
	localparam logic [26:0] N_MUL    = 27'(((64'd1 << N_SHIFT) + 64'd146096) / 64'd146097);
	localparam int          K_SHIFT  = 35;
	localparam logic [24:0] K_MUL    = 25'(((64'd1 << K_SHIFT) + 64'd1460) / 64'd1461);
	localparam int          NJ_SHIFT = 20;
	localparam logic [11:0] NJ_MUL   = 12'(((64'd1 << NJ_SHIFT) + 64'd364) / 64'd365);
	localparam int          I_SHIFT  = 49;
	localparam logic [28:0] I_MUL    = 29'(((64'd1 << I_SHIFT) + 64'd1461000) / 64'd1461001);
	localparam int          M_SHIFT  = 28;
	localparam logic [16:0] M_MUL    = 17'(((64'd1 << M_SHIFT) + 64'd2446) / 64'd2447);

	typedef struct packed {
		logic [23:0] dnum;
		logic [31:0] dfrac;
		logic        sel;
	} dncd_item_t;

	typedef struct packed {
		logic signed [15:0] year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic [31:0]        day_fraction;
	} dncd_date_t;

	// day-index offset of month index m (m = 1 is March), subtracted to give the day of month: floor(2447 * m / 80)
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd0: r = 9'd0;
			4'd1: r = 9'd30;
			4'd2: r = 9'd61;
			4'd3: r = 9'd91;
			4'd4: r = 9'd122;
			4'd5: r = 9'd152;
			4'd6: r = 9'd183;
			4'd7: r = 9'd214;
			4'd8: r = 9'd244;
			4'd9: r = 9'd275;
			4'd10: r = 9'd305;
			4'd11: r = 9'd336;
			4'd12: r = 9'd367;
			4'd13: r = 9'd397;
			4'd14: r = 9'd428;
			4'd15: r = 9'd458;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/dncd_if.sv =====
`default_nettype none

interface dncd_in_if;
	logic        valid;
	logic        ready;
	logic [22:0] jd_whole;
	logic [31:0] jd_fraction;

	modport source (output valid, output jd_whole, output jd_fraction, input ready);
	modport sink (input valid, input jd_whole, input jd_fraction, output ready);
endinterface

interface dncd_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] year;
	logic [3:0]         month;
	logic [4:0]         day;
	logic [31:0]        day_fraction;

	modport source (output valid, output year, output month, output day, output day_fraction,
		input ready);
	modport sink (input valid, input year, input month, input day, input day_fraction,
		output ready);
endinterface

interface dncd_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/dncd_core.sv =====
`default_nettype none

module dncd_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire dncd_pkg::dncd_item_t in_item,
	output logic                      out_valid,
	output dncd_pkg::dncd_date_t      out_date
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	logic [25:0] l4_s1;
	logic [23:0] jm1_s1;
	logic [31:0] dfrac_s1, dfrac_s2, dfrac_s3, dfrac_s4, dfrac_s5, dfrac_s6, dfrac_s7;
	logic        sel_s1, sel_s2, sel_s3, sel_s4, sel_s5;

	logic [23:0] l_s2, jm1_s2;
	logic [7:0]  n_s2, n_s3, n_s4, n_s5;
	logic [12:0] k_s2, k_s3, k_s4, k_s5;

	logic [15:0] l2_s3, l2_s4, l2_s5;
	logic [10:0] lm1_s3, lm1_s4;

	logic [27:0] x_s4;
	logic [1:0]  nj_s4, nj_s5;

	logic [6:0]  i_s5;
	logic [8:0]  ij_s5;

	logic [8:0]  t_s6, t_s7;
	logic [15:0] yb_s6, yb_s7;
	logic [3:0]  m_s7;

	dncd_pkg::dncd_date_t date_s8;

	logic [52:0] n_prod;
	logic [48:0] k_prod;
	logic [25:0] cent;
	logic [22:0] nj_prod;
	logic [2:0]  nj_full;
	logic [56:0] i_prod;
	logic [16:0] l3_full;
	logic [8:0]  l3;
	logic [16:0] yb_greg, yb_jul;
	logic [15:0] x80;
	logic [32:0] m_prod;
	logic        q;

	always_comb begin
		n_prod  = 53'(l4_s1) * 53'(dncd_pkg::N_MUL);
		k_prod  = 49'(jm1_s1) * 49'(dncd_pkg::K_MUL);
		cent    = 26'((27'(n_s2) * 27'd146097 + 27'd3) >> 2);
		nj_prod = 23'(lm1_s3) * 23'(dncd_pkg::NJ_MUL);
		nj_full = nj_prod[dncd_pkg::NJ_SHIFT +: 3] - 3'((lm1_s3 == 11'd1460) ? 1 : 0);
		i_prod  = 57'(x_s4) * 57'(dncd_pkg::I_MUL);
		l3_full = 17'(l2_s5) - 17'((18'(i_s5) * 18'd1461) >> 2) + 17'd31;
		l3      = l3_full[8:0];
		yb_greg = 17'(n_s5) * 17'd100 - 17'd4900 + 17'(i_s5);
		yb_jul  = 17'(k_s5) * 17'd4 + 17'(nj_s5) - 17'd4716;
		x80     = 16'(t_s6) * 16'd80;
		m_prod  = 33'(x80) * 33'(dncd_pkg::M_MUL);
		q       = (m_s7 >= 4'd11);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l4_s1    <= {in_item.dnum + dncd_pkg::GREG_OFFSET, 2'b00};
			jm1_s1   <= in_item.dnum + dncd_pkg::JUL_OFFSET;
			dfrac_s1 <= in_item.dfrac;
			sel_s1   <= in_item.sel;

			l_s2     <= l4_s1[25:2];
			n_s2     <= n_prod[dncd_pkg::N_SHIFT +: 8];
			k_s2     <= k_prod[dncd_pkg::K_SHIFT +: 13];
			jm1_s2   <= jm1_s1;
			dfrac_s2 <= dfrac_s1;
			sel_s2   <= sel_s1;

			l2_s3    <= 16'(l_s2 - 24'(cent));
			lm1_s3   <= 11'(jm1_s2 - 24'(k_s2) * 24'd1461);
			n_s3     <= n_s2;
			k_s3     <= k_s2;
			dfrac_s3 <= dfrac_s2;
			sel_s3   <= sel_s2;

			x_s4     <= 28'(l2_s3 + 16'd1) * 28'd4000;
			nj_s4    <= nj_full[1:0];
			lm1_s4   <= lm1_s3;
			l2_s4    <= l2_s3;
			n_s4     <= n_s3;
			k_s4     <= k_s3;
			dfrac_s4 <= dfrac_s3;
			sel_s4   <= sel_s3;

			i_s5     <= i_prod[dncd_pkg::I_SHIFT +: 7];
			ij_s5    <= 9'(lm1_s4 + 11'd31 - 11'(nj_s4) * 11'd365);
			nj_s5    <= nj_s4;
			l2_s5    <= l2_s4;
			n_s5     <= n_s4;
			k_s5     <= k_s4;
			dfrac_s5 <= dfrac_s4;
			sel_s5   <= sel_s4;

			t_s6     <= sel_s5 ? ij_s5 : l3;
			yb_s6    <= sel_s5 ? yb_jul[15:0] : yb_greg[15:0];
			dfrac_s6 <= dfrac_s5;

			m_s7     <= m_prod[dncd_pkg::M_SHIFT +: 4];
			t_s7     <= t_s6;
			yb_s7    <= yb_s6;
			dfrac_s7 <= dfrac_s6;

			date_s8.day          <= 5'(t_s7 - dncd_pkg::month_start(m_s7));
			date_s8.month        <= q ? 4'(m_s7 - 4'd10) : 4'(m_s7 + 4'd2);
			date_s8.year         <= signed'(yb_s7 + 16'(q));
			date_s8.day_fraction <= dfrac_s7;
		end
	end

	assign out_valid = v_s8;
	assign out_date  = date_s8;

endmodule

`default_nettype wire

// ===== rtl/day_number_to_calendar_date.sv =====
// Julian date to calendar date. Takes a noon-based day count and a 0.32 day fraction and
// returns the astronomical year, month, day and the fraction of the day since midnight,
// under Gregorian rules (calendar select 0, the reset value) or Julian rules (select 1).
// Throughput is one beat per clock while output beats are taken; a result passes through the
// eight register stages of the datapath, each holding at most two constant-reciprocal
// multiplies. When the output beat is not taken the whole pipeline holds,
// and input ready drops. Write the calendar select only while no beat is in flight.
`default_nettype none

module day_number_to_calendar_date (
	input wire logic  clk,
	input wire logic  arst_n,
	dncd_in_if.sink   jd,
	dncd_out_if.source date,
	dncd_cfg_if.sink  cfg
);

	logic                 cal_sel_q;
	logic                 en;
	logic                 out_valid;
	dncd_pkg::dncd_item_t item;
	dncd_pkg::dncd_date_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_sel_q <= 1'b0;
		end else if (cfg.valid) begin
			cal_sel_q <= cfg.data;
		end
	end

	assign cfg.ready = 1'b1;
	assign en        = !out_valid || date.ready;
	assign jd.ready  = en;

	always_comb begin
		item.dnum  = jd.jd_fraction[31] ? 24'(jd.jd_whole) + 24'd1 : 24'(jd.jd_whole);
		item.dfrac = {~jd.jd_fraction[31], jd.jd_fraction[30:0]};
		item.sel   = cal_sel_q;
	end

	dncd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (jd.valid),
		.in_item  (item),
		.out_valid(out_valid),
		.out_date (res)
	);

	assign date.valid        = out_valid;
	assign date.year         = res.year;
	assign date.month        = res.month;
	assign date.day          = res.day;
	assign date.day_fraction = res.day_fraction;

endmodule

`default_nettype wire
